// File: src/rbfd_pkg.sv
// shared types, register indexes and lane arithmetic for the rgb box filter downsampler
package rbfd_pkg;

    // field widths
    localparam int CHAN_W     = 8;
    localparam int LANE_W     = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // reset values of the registers
    localparam logic [1:0] RST_SCALE = 2'd2;
    localparam int         RST_SIZE  = 4096;

    // reciprocal of nine, exact for lane sums below 2**15
    localparam int          RECIP_SHIFT = 15;
    localparam logic [14:0] RECIP_NINE  = 15'd3641;

    // one input item
    typedef struct packed {
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } pixel_t;

    // one result item
    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              row_end;
        logic              frame_end;
    } result_t;

    // three channel sums, blue in the low lane
    typedef struct packed {
        logic [LANE_W-1:0] red;
        logic [LANE_W-1:0] green;
        logic [LANE_W-1:0] blue;
    } lanes_t;

    // finished horizontal block handed from the scan stage to the merge stage
    typedef struct packed {
        lanes_t sum;
        logic   use_store;
        logic   store_wr;
        logic   emit;
        logic   row_end;
        logic   frame_end;
    } blk_op_t;

    // factor code zero runs as factor one
    function automatic logic [1:0] eff_factor(input logic [1:0] s);
        return (s == 2'd0) ? 2'd1 : s;
    endfunction

    // pixel bytes into 12-bit lanes
    function automatic lanes_t widen(input pixel_t p);
        lanes_t r;
        r.red   = LANE_W'(p.in_red);
        r.green = LANE_W'(p.in_green);
        r.blue  = LANE_W'(p.in_blue);
        return r;
    endfunction

    // per-lane add, each lane wraps on its own
    function automatic lanes_t lane_add(input lanes_t a, input lanes_t b);
        lanes_t r;
        r.red   = a.red + b.red;
        r.green = a.green + b.green;
        r.blue  = a.blue + b.blue;
        return r;
    endfunction

    // block sum divided by f*f, low byte kept
    function automatic logic [CHAN_W-1:0] lane_mean(input logic [LANE_W-1:0] s,
                                                    input logic [1:0] f);
        logic [26:0]       prod;
        logic [CHAN_W-1:0] q;
        prod = 27'(s) * 27'(RECIP_NINE);
        case (f)
            2'd2:    q = s[CHAN_W+1:2];
            2'd3:    q = prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
            default: q = s[CHAN_W-1:0];
        endcase
        return q;
    endfunction

endpackage

// File: src/rbfd_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module rbfd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/rbfd_scan.sv
// raster position tracking, horizontal accumulation and column store read issue
module rbfd_scan #(
    parameter int MAX_IN_WIDTH    = 4096,
    parameter int MAX_IN_HEIGHT   = 4096,
    parameter int SUM_STORE_DEPTH = 2048,
    localparam int WW = $clog2(MAX_IN_WIDTH + 1),
    localparam int HW = $clog2(MAX_IN_HEIGHT + 1),
    localparam int AW = $clog2(SUM_STORE_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              restart,
    input  logic              accept,
    input  rbfd_pkg::pixel_t  pix,
    input  logic [1:0]        f,
    input  logic              factor_ok,
    input  logic [WW-1:0]     width,
    input  logic [HW-1:0]     height,
    output logic              op_valid,
    output rbfd_pkg::blk_op_t op,
    output logic [AW-1:0]     op_addr
);

    localparam int DW = $clog2(SUM_STORE_DEPTH + 1);
    localparam int BW = (WW > DW) ? WW : DW;

    logic [WW-1:0]    col_cnt_reg, col_cnt_next;
    logic [WW-1:0]    blk_cnt_reg, blk_cnt_next;
    logic [WW-1:0]    blk_start_reg, blk_start_next;
    logic [HW-1:0]    row_cnt_reg, row_cnt_next;
    logic [HW-1:0]    band_start_reg, band_start_next;
    logic [1:0]       col_ph_reg, col_ph_next;
    logic [1:0]       row_ph_reg, row_ph_next;
    rbfd_pkg::lanes_t acc_reg, acc_next;

    logic [1:0]       f_m1;
    logic             col_fits, col_last, store_ok;
    logic             band_fits, band_last;
    logic             in_range, blk_done;
    logic             col_wrap, row_wrap;
    rbfd_pkg::lanes_t acc_sum;

    // block and band bounds from the start of the current block and band
    always_comb
    begin
        f_m1      = f - 2'd1;
        col_fits  = ((WW+1)'(blk_start_reg) + (WW+1)'(f)) <= (WW+1)'(width);
        store_ok  = (f == 2'd1) || (BW'(blk_cnt_reg) < BW'(SUM_STORE_DEPTH));
        col_last  = (((WW+1)'(blk_start_reg) + (WW+1)'({f, 1'b0})) > (WW+1)'(width))
                    || ((f != 2'd1) && (BW'(blk_cnt_reg) == BW'(SUM_STORE_DEPTH - 1)));
        band_fits = ((HW+1)'(band_start_reg) + (HW+1)'(f)) <= (HW+1)'(height);
        band_last = ((HW+1)'(band_start_reg) + (HW+1)'({f, 1'b0})) > (HW+1)'(height);
        in_range  = col_fits && store_ok && band_fits;
        blk_done  = in_range && (col_ph_reg == f_m1);
        col_wrap  = ((WW+1)'(col_cnt_reg) + (WW+1)'(1)) >= (WW+1)'(width);
        row_wrap  = ((HW+1)'(row_cnt_reg) + (HW+1)'(1)) >= (HW+1)'(height);
        acc_sum   = rbfd_pkg::lane_add(acc_reg, rbfd_pkg::widen(pix));
    end

    // finished block op and store read address
    always_comb
    begin
        op_valid     = accept && blk_done;
        op.sum       = acc_sum;
        op.use_store = (row_ph_reg != 2'd0);
        op.store_wr  = (row_ph_reg != f_m1);
        op.emit      = (row_ph_reg == f_m1) && factor_ok;
        op.row_end   = col_last;
        op.frame_end = col_last && band_last;
        op_addr      = AW'(blk_cnt_reg);
    end

    // next position and accumulator
    always_comb
    begin
        col_cnt_next    = col_cnt_reg;
        blk_cnt_next    = blk_cnt_reg;
        blk_start_next  = blk_start_reg;
        row_cnt_next    = row_cnt_reg;
        band_start_next = band_start_reg;
        col_ph_next     = col_ph_reg;
        row_ph_next     = row_ph_reg;
        acc_next        = acc_reg;
        if (restart)
        begin
            col_cnt_next    = '0;
            blk_cnt_next    = '0;
            blk_start_next  = '0;
            row_cnt_next    = '0;
            band_start_next = '0;
            col_ph_next     = '0;
            row_ph_next     = '0;
            acc_next        = '0;
        end
        else if (accept)
        begin
            if (blk_done)
            begin
                acc_next = '0;
            end
            else if (in_range)
            begin
                acc_next = acc_sum;
            end
            if (col_wrap)
            begin
                col_cnt_next   = '0;
                blk_cnt_next   = '0;
                blk_start_next = '0;
                col_ph_next    = '0;
                acc_next       = '0;
                if (row_wrap)
                begin
                    row_cnt_next    = '0;
                    band_start_next = '0;
                    row_ph_next     = '0;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + HW'(1);
                    if (row_ph_reg >= f_m1)
                    begin
                        row_ph_next     = '0;
                        band_start_next = band_start_reg + HW'(f);
                    end
                    else
                    begin
                        row_ph_next = row_ph_reg + 2'd1;
                    end
                end
            end
            else
            begin
                col_cnt_next = col_cnt_reg + WW'(1);
                if (col_ph_reg >= f_m1)
                begin
                    col_ph_next    = '0;
                    blk_cnt_next   = blk_cnt_reg + WW'(1);
                    blk_start_next = blk_start_reg + WW'(f);
                end
                else
                begin
                    col_ph_next = col_ph_reg + 2'd1;
                end
            end
        end
    end

    // position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg    <= '0;
            blk_cnt_reg    <= '0;
            blk_start_reg  <= '0;
            row_cnt_reg    <= '0;
            band_start_reg <= '0;
            col_ph_reg     <= '0;
            row_ph_reg     <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            col_cnt_reg    <= col_cnt_next;
            blk_cnt_reg    <= blk_cnt_next;
            blk_start_reg  <= blk_start_next;
            row_cnt_reg    <= row_cnt_next;
            band_start_reg <= band_start_next;
            col_ph_reg     <= col_ph_next;
            row_ph_reg     <= row_ph_next;
            acc_reg        <= acc_next;
        end
    end

endmodule

// File: src/rbfd_merge.sv
// adds the stored column sum where used, writes it back or divides it into the output register
module rbfd_merge #(
    parameter int SUM_STORE_DEPTH = 2048,
    localparam int AW = $clog2(SUM_STORE_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  rbfd_pkg::blk_op_t op,
    input  logic [AW-1:0]     op_addr,
    input  logic [1:0]        f,
    input  rbfd_pkg::lanes_t  rd_data,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output rbfd_pkg::lanes_t  wr_data,
    output logic              hold,
    output logic              out_valid,
    input  logic              out_stall,
    output rbfd_pkg::result_t out_item
);

    logic               s1_valid_reg, s1_valid_next;
    rbfd_pkg::blk_op_t  s1_op_reg, s1_op_next;
    logic [AW-1:0]      s1_addr_reg, s1_addr_next;
    logic               out_valid_reg, out_valid_next;
    rbfd_pkg::result_t  out_item_reg, out_item_next;

    logic               s1_done;
    logic               s1_emit;
    rbfd_pkg::lanes_t   total;
    rbfd_pkg::result_t  res;

    // vertical sum and block mean
    always_comb
    begin
        total         = s1_op_reg.use_store ? rbfd_pkg::lane_add(rd_data, s1_op_reg.sum)
                                            : s1_op_reg.sum;
        res.out_red   = rbfd_pkg::lane_mean(total.red, f);
        res.out_green = rbfd_pkg::lane_mean(total.green, f);
        res.out_blue  = rbfd_pkg::lane_mean(total.blue, f);
        res.row_end   = s1_op_reg.row_end;
        res.frame_end = s1_op_reg.frame_end;
    end

    // stage completes unless its result meets a full, stalled output register
    always_comb
    begin
        s1_done = s1_valid_reg && (!s1_op_reg.emit || !out_valid_reg || !out_stall);
        s1_emit = s1_done && s1_op_reg.emit;
        hold    = s1_valid_reg && !s1_done;
        wr_en   = s1_done && s1_op_reg.store_wr;
        wr_addr = s1_addr_reg;
        wr_data = total;
    end

    // next stage and output state
    always_comb
    begin
        s1_valid_next = op_valid ? 1'b1 : (s1_done ? 1'b0 : s1_valid_reg);
        s1_op_next    = op_valid ? op : s1_op_reg;
        s1_addr_next  = op_valid ? op_addr : s1_addr_reg;
        if (s1_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
        out_item_next = s1_emit ? res : out_item_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        s1_op_reg    <= s1_op_next;
        s1_addr_reg  <= s1_addr_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: src/rgb_box_filter_downsampler.sv
// A pixel that closes a block goes to the merge stage register, then its result to the output register.
// Throughput: one pixel per cycle unless stalled; column store read at block close, written back by merge.
// in_stall rises only while a result waits in the merge stage behind a full, stalled output.
// Reset: position, phases and accumulator cleared, factor 2, sizes 4096 (held to the maximum).
// The column store is not cleared; every entry is written by the first row of a band before use.
module rgb_box_filter_downsampler #(
    parameter int MAX_IN_WIDTH    = 4096,
    parameter int MAX_IN_HEIGHT   = 4096,
    parameter int SUM_STORE_DEPTH = 2048
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rbfd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rbfd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  rbfd_pkg::pixel_t                      in_item,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output rbfd_pkg::result_t                     out_item
);

    localparam int WW    = $clog2(MAX_IN_WIDTH + 1);
    localparam int HW    = $clog2(MAX_IN_HEIGHT + 1);
    localparam int AW    = $clog2(SUM_STORE_DEPTH);
    localparam int CMW   = (WW > rbfd_pkg::CFG_DATA_W) ? WW : rbfd_pkg::CFG_DATA_W;
    localparam int CMH   = (HW > rbfd_pkg::CFG_DATA_W) ? HW : rbfd_pkg::CFG_DATA_W;
    localparam int W_RST = (MAX_IN_WIDTH < rbfd_pkg::RST_SIZE) ? MAX_IN_WIDTH
                                                              : rbfd_pkg::RST_SIZE;
    localparam int H_RST = (MAX_IN_HEIGHT < rbfd_pkg::RST_SIZE) ? MAX_IN_HEIGHT
                                                               : rbfd_pkg::RST_SIZE;

    logic [1:0]        scale_reg, scale_next;
    logic [WW-1:0]     width_reg, width_next;
    logic [HW-1:0]     height_reg, height_next;

    logic              cfg_wr;
    logic              restart;
    logic [CMW-1:0]    data_w;
    logic [CMH-1:0]    data_h;
    logic [WW-1:0]     width_sat;
    logic [HW-1:0]     height_sat;
    logic [1:0]        f_eff;
    logic              factor_ok;
    logic              accept;

    logic              op_valid;
    rbfd_pkg::blk_op_t op;
    logic [AW-1:0]     op_addr;
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    rbfd_pkg::lanes_t  ram_wr_data;
    rbfd_pkg::lanes_t  ram_rd_data;
    logic              ram_rd_en;
    logic              hold;

    // sizes held to 1..max as they are written
    always_comb
    begin
        data_w     = CMW'(cfg_data);
        data_h     = CMH'(cfg_data);
        width_sat  = (data_w == '0) ? WW'(1)
                   : ((data_w > CMW'(MAX_IN_WIDTH)) ? WW'(MAX_IN_WIDTH) : WW'(data_w));
        height_sat = (data_h == '0) ? HW'(1)
                   : ((data_h > CMH'(MAX_IN_HEIGHT)) ? HW'(MAX_IN_HEIGHT) : HW'(data_h));
    end

    // register writes; a write to a known register restarts the frame
    always_comb
    begin
        cfg_ready   = 1'b1;
        cfg_wr      = cfg_valid && cfg_ready;
        scale_next  = scale_reg;
        width_next  = width_reg;
        height_next = height_reg;
        restart     = 1'b0;
        if (cfg_wr)
        begin
            case (cfg_index)
                rbfd_pkg::CFG_SCALE:
                begin
                    scale_next = cfg_data[1:0];
                    restart    = 1'b1;
                end
                rbfd_pkg::CFG_WIDTH:
                begin
                    width_next = width_sat;
                    restart    = 1'b1;
                end
                rbfd_pkg::CFG_HEIGHT:
                begin
                    height_next = height_sat;
                    restart     = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= rbfd_pkg::RST_SCALE;
            width_reg  <= WW'(W_RST);
            height_reg <= HW'(H_RST);
        end
        else
        begin
            scale_reg  <= scale_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // handshake and factor decode
    always_comb
    begin
        f_eff     = rbfd_pkg::eff_factor(scale_reg);
        factor_ok = (scale_reg != 2'd0);
        in_stall  = hold;
        accept    = in_valid && !in_stall;
        ram_rd_en = op_valid && op.use_store;
    end

    rbfd_scan #(
        .MAX_IN_WIDTH    (MAX_IN_WIDTH),
        .MAX_IN_HEIGHT   (MAX_IN_HEIGHT),
        .SUM_STORE_DEPTH (SUM_STORE_DEPTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .accept    (accept),
        .pix       (in_item),
        .f         (f_eff),
        .factor_ok (factor_ok),
        .width     (width_reg),
        .height    (height_reg),
        .op_valid  (op_valid),
        .op        (op),
        .op_addr   (op_addr)
    );

    rbfd_ram #(
        .WIDTH (36),
        .DEPTH (SUM_STORE_DEPTH)
    ) u_sum_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (op_addr),
        .rd_data (ram_rd_data)
    );

    rbfd_merge #(
        .SUM_STORE_DEPTH (SUM_STORE_DEPTH)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op        (op),
        .op_addr   (op_addr),
        .f         (f_eff),
        .rd_data   (ram_rd_data),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .hold      (hold),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

`ifndef ASSERT_OFF
    // a write back never lands on the entry being read in the same cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != op_addr))
        else $error("column store read and write hit the same entry");

    // the column store is only touched for factors above one
    a_store_factor: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_rd_en || ram_wr_en) |-> (f_eff != 2'd1))
        else $error("column store used with factor one");

    // input stalls only behind a full, stalled output register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // the last item of the frame also closes its row
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.frame_end) |-> out_item.row_end)
        else $error("frame end without row end");
`endif

endmodule
